// ===== design/psi_pkg.sv =====
// shared types and constants for the power spectrum integrator
`timescale 1ns / 1ps
package psi_pkg;

   localparam logic [7:0] RESET_FLAG = 8'd63;

   localparam logic [7:0] CSR_SPECTRUM_BINS      = 8'd0;
   localparam logic [7:0] CSR_SPECTRA_TO_AVERAGE = 8'd1;

   localparam logic [12:0] SPECTRUM_BINS_RESET      = 13'd4096;
   localparam logic [15:0] SPECTRA_TO_AVERAGE_RESET = 16'd8;

   typedef struct packed {
      logic [7:0]  sideband_code;
      logic [7:0]  polarization_code;
      logic [31:0] acquisition_second;
      logic [31:0] rate_of_sampling;
      logic [63:0] first_sample_index;
      logic [15:0] spectra_in_item;
      logic [16:0] transform_length;
      logic [11:0] bin_number;
      logic [31:0] bin_power;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_sideband;
      logic [7:0]  out_polarization;
      logic [31:0] out_second;
      logic [31:0] out_rate;
      logic [63:0] out_first_index;
      logic [31:0] total_spectra;
      logic [63:0] total_samples;
      logic [11:0] out_bin;
      logic [31:0] average_power;
      logic        last_of_run;
   } rsp_type;

   typedef struct packed {
      logic start;
      logic done;
   } div_ctrl_type;

endpackage

// ===== design/psi_ram.sv =====
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
module psi_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== design/psi_divider.sv =====
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module psi_divider #(
   parameter int SUM_BITS   = 48,
   parameter int COUNT_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [SUM_BITS-1:0]   dividend,
   input  logic [COUNT_BITS-1:0] divisor,
   output logic                  done,
   output logic [SUM_BITS-1:0]   quotient
);
   localparam int CNT_W = $clog2(SUM_BITS + 1);

   logic [SUM_BITS-1:0]   quot_ff, quot_in;
   logic [COUNT_BITS-1:0] rem_ff, rem_in;
   logic [COUNT_BITS-1:0] div_ff, div_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [COUNT_BITS:0]   trial;
   logic [COUNT_BITS:0]   diff;

   always_comb begin
      trial   = {rem_ff, quot_ff[SUM_BITS-1]};
      diff    = trial - {1'b0, div_ff};
      quot_in = quot_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quot_in = dividend;
         rem_in  = '0;
         div_in  = divisor;
         cnt_in  = CNT_W'(SUM_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in  = diff[COUNT_BITS-1:0];
            quot_in = {quot_ff[SUM_BITS-2:0], 1'b1};
         end else begin
            rem_in  = trial[COUNT_BITS-1:0];
            quot_in = {quot_ff[SUM_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;
endmodule

// ===== design/power_spectrum_integrator_top.sv =====
// top level of the power spectrum integrator
`timescale 1ns / 1ps
// Accumulates power spectra bin by bin into a bin-sum ram and emits the
// floor of each bin's sum over the spectrum count while the final spectrum of
// a run passes. One bin at a time: a bin that emits nothing is accepted with
// a ram read in S_IDLE, then written back in S_READ; an emitting bin then
// runs the bit-serial divider (S_DIV) and the output load (S_OUT), plus any
// wait on rsp_stall. Bins at or above spectrum_bins are dropped. The header
// of a spectrum is checked on bin 0; a mismatch or an empty or completed run
// restarts the run. csr_ready is always high; configure only while idle.
module power_spectrum_integrator_top #(
   parameter int MAX_BINS   = 4096,
   parameter int POWER_BITS = 32,
   parameter int COUNT_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  psi_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output psi_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [7:0]       csr_index,
   input  logic [31:0]      csr_data
);
   import psi_pkg::*;

   localparam int SUM_BITS = POWER_BITS + COUNT_BITS;
   localparam int ADDR_W   = $clog2(MAX_BINS);
   localparam logic [31:0] POWER_MASK =
      (POWER_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << POWER_BITS) - 64'd1);
   localparam logic [16:0] COUNT_MAX = 17'((17'd1 << COUNT_BITS) - 17'd1);
   localparam logic [16:0] MAX_BINS_V = 17'(MAX_BINS);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_READ = 4'b0010,
      S_DIV  = 4'b0100,
      S_OUT  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [12:0] bins_ff;
   logic [15:0] target_ff;

   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [7:0]  sideband_ff, sideband_in;
   logic [7:0]  polar_ff, polar_in;
   logic [31:0] second_ff, second_in;
   logic [31:0] rate_ff, rate_in;
   logic [63:0] first_ff, first_in;
   logic [31:0] run_spectra_ff, run_spectra_in;
   logic [63:0] run_samples_ff, run_samples_in;
   logic [1:0]  mode_ff, mode_in;

   logic [ADDR_W-1:0]   addr_ff;
   logic [11:0]         bin_ff;
   logic [SUM_BITS-1:0] power_ff;
   logic                last_ff;

   logic rsp_valid_ff;
   rsp_type rsp_data_ff;

   logic [16:0] nbins;
   logic [16:0] target;
   logic [16:0] bin_ext;
   logic        in_range;
   logic        accept;
   logic        empty, match;
   logic [32:0] samples;
   logic [32:0] spec_sum;
   logic [64:0] samp_sum;
   logic [16:0] count_next_ext;

   logic [SUM_BITS-1:0] rd_data;
   logic [SUM_BITS-1:0] sum_wr;
   logic [SUM_BITS-1:0] quotient;
   div_ctrl_type div_ctrl;

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         bins_ff   <= SPECTRUM_BINS_RESET;
         target_ff <= SPECTRA_TO_AVERAGE_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_SPECTRUM_BINS) begin
            bins_ff <= csr_data[12:0];
         end else if (csr_index == CSR_SPECTRA_TO_AVERAGE) begin
            target_ff <= csr_data[15:0];
         end
      end
   end

   always_comb begin
      nbins = {4'd0, bins_ff};
      if (nbins == 17'd0) nbins = 17'd1;
      if (nbins > MAX_BINS_V) nbins = MAX_BINS_V;
      target = {1'b0, target_ff};
      if (target == 17'd0) target = 17'd1;
      if (target > COUNT_MAX) target = COUNT_MAX;
      bin_ext  = {5'd0, req_data.bin_number};
      in_range = bin_ext < nbins;
   end

   // header check and run totals, taken on bin 0
   always_comb begin
      samples  = 33'(req_data.spectra_in_item) * 33'(req_data.transform_length);
      spec_sum = {1'b0, run_spectra_ff} + 33'(req_data.spectra_in_item);
      samp_sum = {1'b0, run_samples_ff} + 65'(samples);
      empty = (count_ff == '0) || mode_ff[1];
      match = (req_data.sideband_code == sideband_ff) &&
              (req_data.polarization_code == polar_ff) &&
              (req_data.acquisition_second == second_ff) &&
              (req_data.rate_of_sampling == rate_ff) &&
              (req_data.first_sample_index >= first_ff);
      count_in       = count_ff;
      sideband_in    = sideband_ff;
      polar_in       = polar_ff;
      second_in      = second_ff;
      rate_in        = rate_ff;
      first_in       = first_ff;
      run_spectra_in = run_spectra_ff;
      run_samples_in = run_samples_ff;
      mode_in        = mode_ff;
      if (accept && in_range && req_data.bin_number == 12'd0) begin
         if (empty || !match) begin
            sideband_in    = req_data.sideband_code;
            polar_in       = req_data.polarization_code;
            second_in      = req_data.acquisition_second;
            rate_in        = req_data.rate_of_sampling;
            first_in       = req_data.first_sample_index;
            count_in       = COUNT_BITS'(1);
            run_spectra_in = 32'(req_data.spectra_in_item);
            run_samples_in = 64'(samples);
            mode_in        = 2'b00;
         end else begin
            if (17'(count_ff) < COUNT_MAX) count_in = count_ff + 1'b1;
            run_spectra_in = spec_sum[32] ? 32'hFFFF_FFFF : spec_sum[31:0];
            run_samples_in = samp_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : samp_sum[63:0];
            mode_in        = 2'b01;
         end
         count_next_ext = 17'(count_in);
         if (count_next_ext >= target) mode_in[1] = 1'b1;
      end else begin
         count_next_ext = 17'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= '0;
         sideband_ff    <= RESET_FLAG;
         polar_ff       <= RESET_FLAG;
         second_ff      <= '0;
         rate_ff        <= '0;
         first_ff       <= '0;
         run_spectra_ff <= '0;
         run_samples_ff <= '0;
         mode_ff        <= 2'b00;
      end else begin
         count_ff       <= count_in;
         sideband_ff    <= sideband_in;
         polar_ff       <= polar_in;
         second_ff      <= second_in;
         rate_ff        <= rate_in;
         first_ff       <= first_in;
         run_spectra_ff <= run_spectra_in;
         run_samples_ff <= run_samples_in;
         mode_ff        <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         addr_ff  <= bin_ext[ADDR_W-1:0];
         bin_ff   <= req_data.bin_number;
         power_ff <= SUM_BITS'(req_data.bin_power & POWER_MASK);
         last_ff  <= (bin_ext == nbins - 17'd1);
      end
   end

   psi_ram #(
      .WIDTH(SUM_BITS),
      .DEPTH(MAX_BINS)
   ) u_sums (
      .clock   (clock),
      .wr_en   (state_ff == S_READ),
      .wr_addr (addr_ff),
      .wr_data (sum_wr),
      .rd_en   (accept),
      .rd_addr (bin_ext[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   assign sum_wr = mode_ff[0] ? (rd_data + power_ff) : power_ff;
   assign div_ctrl.start = (state_ff == S_READ) && mode_ff[1];

   psi_divider #(
      .SUM_BITS   (SUM_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_ctrl.start),
      .dividend (sum_wr),
      .divisor  (count_ff),
      .done     (div_ctrl.done),
      .quotient (quotient)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (accept && in_range) state_in = S_READ;
         S_READ: state_in = mode_ff[1] ? S_DIV : S_IDLE;
         S_DIV:  if (div_ctrl.done) state_in = S_OUT;
         S_OUT:  if (!rsp_valid_ff || !rsp_stall) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_OUT && (!rsp_valid_ff || !rsp_stall)) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_OUT && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_data_ff.out_sideband     <= sideband_ff;
         rsp_data_ff.out_polarization <= polar_ff;
         rsp_data_ff.out_second       <= second_ff;
         rsp_data_ff.out_rate         <= rate_ff;
         rsp_data_ff.out_first_index  <= first_ff;
         rsp_data_ff.total_spectra    <= run_spectra_ff;
         rsp_data_ff.total_samples    <= run_samples_ff;
         rsp_data_ff.out_bin          <= bin_ff;
         rsp_data_ff.average_power    <= 32'(quotient);
         rsp_data_ff.last_of_run      <= last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
endmodule

// ===== design/psi_checker.sv =====
// port-level checks for the power spectrum integrator, bound to the top
`timescale 1ns / 1ps
module psi_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input psi_pkg::rsp_type rsp_data,
   input logic             csr_ready
);
   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // stalled request stays
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid)
      else $error("request dropped while stalled");

   // a new result appears only while the block was busy with an item
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without a busy block");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("config port not ready");
endmodule

bind power_spectrum_integrator_top psi_checker u_psi_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data),
   .csr_ready (csr_ready)
);
